FILE: sv/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// shared constants and types of the 2 MiB page table builder
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int NUM_TABLES = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int TBL_W = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int NXT_W = $clog2(NUM_TABLES + 1);
  localparam int SLOT_W = $clog2(ENTRIES_PER_TABLE);
  localparam int ADDR_W = TBL_W + SLOT_W;
  localparam int DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
  localparam int PAGE_SHIFT = 12;

  localparam logic [11:0] FLAGS_LINK = 12'h003;  // rw | p
  localparam logic [11:0] FLAGS_LEAF = 12'h083;  // ps | rw | p

  localparam logic OP_MAP = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_FREE, ST_RD, ST_CHK, ST_SCAN, ST_ZERO, ST_LINK, ST_DIRW, ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    WR_NONE, WR_ZERO, WR_LINK, WR_DIR
  } wr_e;

  typedef struct packed {
    logic capture;
    logic start_walk;
    logic rd;
    logic follow;
    logic scan_init;
    logic scan_step;
    logic zero_step;
    wr_e  wr;
    logic link_adv;
    logic free_apply;
    logic set_status;
    logic status_val;
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic present;
    logic link_ok;
    logic level;
    logic scan_found;
    logic scan_fail;
    logic zero_last;
  } sts_t;

endpackage

FILE: sv/page_table_builder_with_bitmap_alloc_core.sv
// ----------------------------------------------------------------------------
// page_table_builder_with_bitmap_alloc_core
// builds x86-64 style tables for 2 MiB pages with a bitmap table allocator
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its status comes back
// on status_o with done_o high for one cycle and cannot be held off. A free goes
// from ST_FREE straight to ST_DONE. A map through present entries reads and checks
// the entry at each of the two levels and then writes the directory entry; each
// table it has to allocate adds the bitmap scan (one bitmap position per cycle)
// and the zeroing of its 512 entries and the link write, as the single store port
// moves one entry per cycle. After reset busy stays high while the root table is
// cleared; table_base writes are taken meanwhile.
module page_table_builder_with_bitmap_alloc_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [47:0] virtual_address_i,
  input  logic [51:0] physical_address_i,
  input  logic [51:0] table_address_i,
  output logic        done_o,
  output logic        status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ptb_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        cfg_we;
  logic [51:0] table_base;

  // only register zero exists, at byte address 0
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[3];
  assign prdata = paddr[3] ? 64'b0 : {12'b0, table_base};

  ptb_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  ptb_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (pwdata[51:0]),
    .table_base_o      (table_base),
    .operation_i       (operation_i),
    .virtual_address_i (virtual_address_i),
    .physical_address_i(physical_address_i),
    .table_address_i   (table_address_i),
    .status_o          (status_o)
  );

endmodule

FILE: sv/ptb_ram.sv
// ----------------------------------------------------------------------------
// ptb_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ptb_ctrl.sv
// ----------------------------------------------------------------------------
// ptb_ctrl
// sequencer for map and free requests
// ----------------------------------------------------------------------------
module ptb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  ptb_pkg::sts_t sts_i,
  output ptb_pkg::cmd_t cmd_o
);
  import ptb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.wr = WR_NONE;
    busy = (state_q != ST_IDLE);
    done_o = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        // root table cleared after reset
        cmd_o.wr = WR_ZERO;
        cmd_o.zero_step = 1'b1;
        if (sts_i.zero_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = ST_FREE;
        end
      end
      ST_FREE: begin
        if (sts_i.op_free) begin
          cmd_o.free_apply = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = STATUS_DONE;
          state_d = ST_DONE;
        end else begin
          cmd_o.start_walk = 1'b1;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (sts_i.present) begin
          if (!sts_i.link_ok) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status_val = STATUS_FULL;
            state_d = ST_DONE;
          end else begin
            cmd_o.follow = 1'b1;
            state_d = sts_i.level ? ST_DIRW : ST_RD;
          end
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_found) begin
          state_d = ST_ZERO;
        end else if (sts_i.scan_fail) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = STATUS_FULL;
          state_d = ST_DONE;
        end
      end
      ST_ZERO: begin
        cmd_o.wr = WR_ZERO;
        cmd_o.zero_step = 1'b1;
        if (sts_i.zero_last) state_d = ST_LINK;
      end
      ST_LINK: begin
        cmd_o.wr = WR_LINK;
        cmd_o.link_adv = 1'b1;
        state_d = sts_i.level ? ST_DIRW : ST_RD;
      end
      ST_DIRW: begin
        cmd_o.wr = WR_DIR;
        cmd_o.set_status = 1'b1;
        cmd_o.status_val = STATUS_DONE;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        done_o = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/ptb_dp.sv
// ----------------------------------------------------------------------------
// ptb_dp
// datapath: request registers, bitmap allocator, table store and entry muxing
// ----------------------------------------------------------------------------
module ptb_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ptb_pkg::cmd_t cmd_i,
  output ptb_pkg::sts_t sts_o,
  input  logic          cfg_we_i,
  input  logic [51:0]   cfg_wdata_i,
  output logic [51:0]   table_base_o,
  input  logic          operation_i,
  input  logic [47:0]   virtual_address_i,
  input  logic [51:0]   physical_address_i,
  input  logic [51:0]   table_address_i,
  output logic          status_o
);
  import ptb_pkg::*;

  logic [51:0]       base_q;
  logic              op_q;
  logic [47:0]       va_q;
  logic [51:0]       pa_q;
  logic [51:0]       ta_q;
  logic [NUM_TABLES-1:0] inuse_q;
  logic [NXT_W-1:0]  next_q;
  logic              wrap_q;
  logic [TBL_W-1:0]  cur_q;
  logic [TBL_W-1:0]  child_q;
  logic              level_q;
  logic [SLOT_W-1:0] cnt_q;
  logic              status_q;

  logic [ADDR_W-1:0] ram_addr;
  logic [63:0]       ram_wdata;
  logic [63:0]       ram_rdata;
  logic [SLOT_W-1:0] slot;
  logic [40:0]       link_sum;
  logic [40:0]       diff_link;
  logic [40:0]       diff_free;
  logic              link_ok;
  logic              free_ok;
  logic              in_range;
  logic              scan_found;

  assign slot = level_q ? va_q[38:30] : va_q[47:39];

  // page numbers relative to the aligned base
  assign diff_link = {5'b0, ram_rdata[47:12]} - {1'b0, base_q[51:12]};
  assign diff_free = {1'b0, ta_q[51:12]} - {1'b0, base_q[51:12]};
  assign link_ok = !diff_link[40] && (diff_link[39:0] < 40'(NUM_TABLES));
  assign free_ok = !diff_free[40] && (diff_free[39:0] < 40'(NUM_TABLES));

  assign link_sum = {1'b0, base_q[51:12]} + 41'(child_q);

  assign in_range = (next_q < NXT_W'(NUM_TABLES));
  assign scan_found = in_range && !inuse_q[next_q[TBL_W-1:0]];

  always_comb begin
    ram_addr = {cur_q, slot};
    ram_wdata = '0;
    case (cmd_i.wr)
      WR_ZERO: ram_addr = {child_q, cnt_q};
      WR_LINK: ram_wdata = {11'b0, link_sum, FLAGS_LINK};
      WR_DIR: begin
        ram_addr = {cur_q, va_q[29:21]};
        ram_wdata = {12'b0, pa_q[51:12], FLAGS_LEAF};
      end
      default: ;
    endcase
  end

  ptb_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr != WR_NONE),
    .re_i   (cmd_i.rd),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= operation_i;
      va_q <= virtual_address_i;
      pa_q <= physical_address_i;
      ta_q <= table_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= 52'h200000;
      inuse_q  <= NUM_TABLES'(1);
      next_q   <= NXT_W'(1);
      wrap_q   <= 1'b0;
      cur_q    <= '0;
      child_q  <= '0;
      level_q  <= 1'b0;
      cnt_q    <= '0;
      status_q <= STATUS_DONE;
    end else begin
      if (cfg_we_i) base_q <= cfg_wdata_i;
      if (cmd_i.start_walk) begin
        cur_q <= '0;
        level_q <= 1'b0;
      end
      if (cmd_i.follow) begin
        cur_q <= diff_link[TBL_W-1:0];
        level_q <= 1'b1;
      end
      if (cmd_i.link_adv) begin
        cur_q <= child_q;
        level_q <= 1'b1;
      end
      if (cmd_i.scan_init) wrap_q <= 1'b0;
      if (cmd_i.scan_step) begin
        if (scan_found) begin
          inuse_q[next_q[TBL_W-1:0]] <= 1'b1;
          child_q <= next_q[TBL_W-1:0];
          next_q <= next_q + 1'b1;
        end else if (!in_range) begin
          if (!wrap_q) begin
            next_q <= '0;
            wrap_q <= 1'b1;
          end
        end else begin
          next_q <= next_q + 1'b1;
        end
      end
      if (cmd_i.zero_step) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.free_apply && free_ok) inuse_q[diff_free[TBL_W-1:0]] <= 1'b0;
      if (cmd_i.set_status) status_q <= cmd_i.status_val;
    end
  end

  assign sts_o.op_free = (op_q == OP_FREE);
  assign sts_o.present = ram_rdata[0];
  assign sts_o.link_ok = link_ok;
  assign sts_o.level = level_q;
  assign sts_o.scan_found = scan_found;
  assign sts_o.scan_fail = !in_range && wrap_q;
  assign sts_o.zero_last = (cnt_q == SLOT_W'(ENTRIES_PER_TABLE - 1));

  assign table_base_o = base_q;
  assign status_o = status_q;

endmodule
